FILE: rtl/ec_point_add_and_scalar_mult_core_assert.svh
// Assertion macros for the point arithmetic core.
`ifndef EC_POINT_ADD_AND_SCALAR_MULT_CORE_ASSERT_SVH
`define EC_POINT_ADD_AND_SCALAR_MULT_CORE_ASSERT_SVH

// Checked on every edge out of reset.
`define ECPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define ECPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/ecpa_pkg.sv
package ecpa_pkg;

  localparam int W      = 16;
  localparam int PC_W   = 6;
  localparam int SRC_W  = 5;
  localparam int RA_W   = 4;
  localparam int DEPTH  = 16;
  localparam int STEP_W = $clog2(W);

  typedef enum logic [3:0] {
    OP_NOP, OP_MOV, OP_ADD, OP_SUB, OP_RED, OP_MUL, OP_DIV, OP_CMP, OP_OUTX, OP_OUTY
  } op_e;

  typedef enum logic [3:0] {
    C_NEXT, C_ALWAYS, C_NE, C_AZ, C_SCALAR, C_PSMALL, C_KZERO, C_CNTLE1, C_RINF
  } cond_e;

  typedef enum logic [2:0] {
    A_NONE, A_CLR_RINF, A_SET_RINF, A_CNT_DEC, A_FINISH
  } act_e;

  typedef logic [SRC_W-1:0] src_t;
  typedef logic [PC_W-1:0]  pc_t;

  // scratch registers
  localparam src_t R_X1   = 5'd0;
  localparam src_t R_Y1   = 5'd1;
  localparam src_t R_X2   = 5'd2;
  localparam src_t R_Y2   = 5'd3;
  localparam src_t R_AM   = 5'd4;
  localparam src_t R_NUM  = 5'd5;
  localparam src_t R_DEN  = 5'd6;
  localparam src_t R_R1   = 5'd7;
  localparam src_t R_R2   = 5'd8;
  localparam src_t R_T1   = 5'd9;
  localparam src_t R_T2   = 5'd10;
  localparam src_t R_TMP  = 5'd11;
  localparam src_t R_S    = 5'd12;
  localparam src_t R_XR   = 5'd13;
  localparam src_t R_YR   = 5'd14;
  localparam src_t R_TMP2 = 5'd15;
  // fixed sources
  localparam src_t S_P    = 5'd16;
  localparam src_t S_ACFG = 5'd17;
  localparam src_t S_FX   = 5'd18;
  localparam src_t S_FY   = 5'd19;
  localparam src_t S_SX   = 5'd20;
  localparam src_t S_SY   = 5'd21;
  localparam src_t S_Q    = 5'd22;
  localparam src_t S_ONE  = 5'd23;

  // microprogram labels
  localparam pc_t L_PADD   = 6'd7;
  localparam pc_t L_DIST   = 6'd15;
  localparam pc_t L_INV    = 6'd17;
  localparam pc_t L_LOOP   = 6'd21;
  localparam pc_t L_SLOPE  = 6'd30;
  localparam pc_t L_RESULT = 6'd39;
  localparam pc_t L_PINF   = 6'd41;
  localparam pc_t L_FIN    = 6'd42;
  localparam pc_t L_SCNEXT = 6'd43;
  localparam pc_t L_REINIT = 6'd46;
  localparam pc_t L_SCEND  = 6'd48;
  localparam pc_t L_SC     = 6'd50;

  typedef struct packed {
    op_e   op;
    src_t  a;
    src_t  b;
    src_t  d;
    cond_e cond;
    pc_t   tgt;
    act_e  act;
  } uop_t;

  typedef struct packed {
    logic capture;
    logic start;
    op_e  op;
    src_t a;
    src_t b;
    src_t d;
    logic cnt_dec;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic eq;
    logic az;
    logic mode_scalar;
    logic p_small;
    logic cnt_zero;
    logic cnt_le1;
  } dp_sts_t;

  function automatic uop_t mk(op_e op, src_t a, src_t b, src_t d, cond_e c, pc_t t, act_e x);
    uop_t u;
    u.op = op; u.a = a; u.b = b; u.d = d; u.cond = c; u.tgt = t; u.act = x;
    return u;
  endfunction

  // Affine add with Euclid inverse, and the scalar loop around it.
  function automatic uop_t uop_at(pc_t pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(OP_NOP, R_X1, R_X1, R_X1, C_PSMALL, L_FIN, A_NONE);
      6'd1:  u = mk(OP_DIV, S_FX, S_P, R_X1, C_NEXT, L_FIN, A_NONE);
      6'd2:  u = mk(OP_DIV, S_FY, S_P, R_Y1, C_NEXT, L_FIN, A_NONE);
      6'd3:  u = mk(OP_DIV, S_ACFG, S_P, R_AM, C_NEXT, L_FIN, A_NONE);
      6'd4:  u = mk(OP_NOP, R_X1, R_X1, R_X1, C_SCALAR, L_SC, A_NONE);
      6'd5:  u = mk(OP_DIV, S_SX, S_P, R_X2, C_NEXT, L_FIN, A_NONE);
      6'd6:  u = mk(OP_DIV, S_SY, S_P, R_Y2, C_NEXT, L_FIN, A_NONE);
      6'd7:  u = mk(OP_CMP, R_X1, R_X2, R_X1, C_NE, L_DIST, A_NONE);
      6'd8:  u = mk(OP_CMP, R_Y1, R_Y2, R_X1, C_NE, L_PINF, A_NONE);
      6'd9:  u = mk(OP_CMP, R_Y1, R_Y1, R_X1, C_AZ, L_PINF, A_NONE);
      6'd10: u = mk(OP_MUL, R_X1, R_X1, R_TMP, C_NEXT, L_FIN, A_NONE);
      6'd11: u = mk(OP_ADD, R_TMP, R_TMP, R_NUM, C_NEXT, L_FIN, A_NONE);
      6'd12: u = mk(OP_ADD, R_NUM, R_TMP, R_NUM, C_NEXT, L_FIN, A_NONE);
      6'd13: u = mk(OP_ADD, R_NUM, R_AM, R_NUM, C_NEXT, L_FIN, A_NONE);
      6'd14: u = mk(OP_ADD, R_Y1, R_Y1, R_DEN, C_ALWAYS, L_INV, A_NONE);
      6'd15: u = mk(OP_SUB, R_Y2, R_Y1, R_NUM, C_NEXT, L_FIN, A_NONE);
      6'd16: u = mk(OP_SUB, R_X2, R_X1, R_DEN, C_NEXT, L_FIN, A_NONE);
      6'd17: u = mk(OP_MOV, S_P, S_P, R_R1, C_NEXT, L_FIN, A_NONE);
      6'd18: u = mk(OP_MOV, R_DEN, R_DEN, R_R2, C_NEXT, L_FIN, A_NONE);
      6'd19: u = mk(OP_SUB, R_DEN, R_DEN, R_T1, C_NEXT, L_FIN, A_NONE);
      6'd20: u = mk(OP_MOV, S_ONE, S_ONE, R_T2, C_NEXT, L_FIN, A_NONE);
      6'd21: u = mk(OP_CMP, R_R2, R_R2, R_X1, C_AZ, L_SLOPE, A_NONE);
      6'd22: u = mk(OP_DIV, R_R1, R_R2, R_TMP, C_NEXT, L_FIN, A_NONE);
      6'd23: u = mk(OP_RED, S_Q, S_P, R_TMP2, C_NEXT, L_FIN, A_NONE);
      6'd24: u = mk(OP_MUL, R_TMP2, R_T2, R_TMP2, C_NEXT, L_FIN, A_NONE);
      6'd25: u = mk(OP_SUB, R_T1, R_TMP2, R_TMP2, C_NEXT, L_FIN, A_NONE);
      6'd26: u = mk(OP_MOV, R_R2, R_R2, R_R1, C_NEXT, L_FIN, A_NONE);
      6'd27: u = mk(OP_MOV, R_TMP, R_TMP, R_R2, C_NEXT, L_FIN, A_NONE);
      6'd28: u = mk(OP_MOV, R_T2, R_T2, R_T1, C_NEXT, L_FIN, A_NONE);
      6'd29: u = mk(OP_MOV, R_TMP2, R_TMP2, R_T2, C_ALWAYS, L_LOOP, A_NONE);
      6'd30: u = mk(OP_MUL, R_NUM, R_T1, R_S, C_NEXT, L_FIN, A_NONE);
      6'd31: u = mk(OP_MUL, R_S, R_S, R_TMP, C_NEXT, L_FIN, A_NONE);
      6'd32: u = mk(OP_SUB, R_TMP, R_X1, R_TMP, C_NEXT, L_FIN, A_NONE);
      6'd33: u = mk(OP_SUB, R_TMP, R_X2, R_XR, C_NEXT, L_FIN, A_NONE);
      6'd34: u = mk(OP_SUB, R_X1, R_XR, R_TMP, C_NEXT, L_FIN, A_NONE);
      6'd35: u = mk(OP_MUL, R_S, R_TMP, R_TMP, C_NEXT, L_FIN, A_NONE);
      6'd36: u = mk(OP_SUB, R_TMP, R_Y1, R_YR, C_NEXT, L_FIN, A_NONE);
      6'd37: u = mk(OP_MOV, R_XR, R_XR, R_X2, C_NEXT, L_FIN, A_CLR_RINF);
      6'd38: u = mk(OP_MOV, R_YR, R_YR, R_Y2, C_SCALAR, L_SCNEXT, A_NONE);
      6'd39: u = mk(OP_OUTX, R_X2, R_X2, R_X1, C_NEXT, L_FIN, A_NONE);
      6'd40: u = mk(OP_OUTY, R_Y2, R_Y2, R_X1, C_ALWAYS, L_FIN, A_NONE);
      6'd41: u = mk(OP_NOP, R_X1, R_X1, R_X1, C_SCALAR, L_SCNEXT, A_SET_RINF);
      6'd42: u = mk(OP_NOP, R_X1, R_X1, R_X1, C_NEXT, L_FIN, A_FINISH);
      6'd43: u = mk(OP_NOP, R_X1, R_X1, R_X1, C_CNTLE1, L_SCEND, A_NONE);
      6'd44: u = mk(OP_NOP, R_X1, R_X1, R_X1, C_RINF, L_REINIT, A_CNT_DEC);
      6'd45: u = mk(OP_NOP, R_X1, R_X1, R_X1, C_ALWAYS, L_PADD, A_NONE);
      6'd46: u = mk(OP_MOV, R_X1, R_X1, R_X2, C_NEXT, L_FIN, A_CLR_RINF);
      6'd47: u = mk(OP_MOV, R_Y1, R_Y1, R_Y2, C_ALWAYS, L_SCNEXT, A_NONE);
      6'd48: u = mk(OP_NOP, R_X1, R_X1, R_X1, C_RINF, L_FIN, A_NONE);
      6'd49: u = mk(OP_NOP, R_X1, R_X1, R_X1, C_ALWAYS, L_RESULT, A_NONE);
      6'd50: u = mk(OP_NOP, R_X1, R_X1, R_X1, C_KZERO, L_FIN, A_NONE);
      6'd51: u = mk(OP_MOV, R_X1, R_X1, R_X2, C_NEXT, L_FIN, A_CLR_RINF);
      6'd52: u = mk(OP_MOV, R_Y1, R_Y1, R_Y2, C_ALWAYS, L_SCNEXT, A_NONE);
      default: u = mk(OP_NOP, R_X1, R_X1, R_X1, C_NEXT, L_FIN, A_FINISH);
    endcase
    return u;
  endfunction

endpackage

FILE: rtl/ecpa_ram.sv
module ecpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/ecpa_datapath.sv
module ecpa_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ecpa_pkg::dp_cmd_t cmd_i,
  output ecpa_pkg::dp_sts_t sts_o,
  input  logic [15:0]       field_prime_i,
  input  logic [15:0]       curve_a_i,
  input  logic              operation_i,
  input  logic [15:0]       first_x_i,
  input  logic [15:0]       first_y_i,
  input  logic [15:0]       second_x_i,
  input  logic [15:0]       second_y_i,
  input  logic [15:0]       scalar_i,
  output logic [15:0]       result_x_o,
  output logic [15:0]       result_y_o
);
  import ecpa_pkg::*;

  typedef enum logic [3:0] {
    D_IDLE  = 4'b0001,
    D_FETCH = 4'b0010,
    D_EXEC  = 4'b0100,
    D_WB    = 4'b1000
  } dstate_e;

  dstate_e           st_q, st_d;
  op_e               op_q;
  src_t              a_q, b_q, d_q;
  logic              mode_q;
  logic [W-1:0]      fx_q, fy_q, sx_q, sy_q, cnt_q, q_q;
  logic [W-1:0]      opb_q, sh_q, acc_q, res_q, resx_q, resy_q, outx_q, outy_q;
  logic [STEP_W-1:0] step_q;
  logic              eq_q, az_q;
  logic [W-1:0]      rdata_a, rdata_b, va, vb, simple;
  logic [W:0]        p_ext, sum, t0, t1, t2;
  logic              ram_we;
  logic [W-1:0]      wb_data;

  assign p_ext = {1'b0, field_prime_i};

  ecpa_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram_a (
    .clk_i, .we_i(ram_we), .waddr_i(d_q[RA_W-1:0]), .wdata_i(wb_data),
    .raddr_i(cmd_i.a[RA_W-1:0]), .rdata_o(rdata_a)
  );
  ecpa_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram_b (
    .clk_i, .we_i(ram_we), .waddr_i(d_q[RA_W-1:0]), .wdata_i(wb_data),
    .raddr_i(cmd_i.b[RA_W-1:0]), .rdata_o(rdata_b)
  );

  function automatic logic [W-1:0] pick(src_t s, logic [W-1:0] ram, logic [W-1:0] p,
                                        logic [W-1:0] ac, logic [W-1:0] fx,
                                        logic [W-1:0] fy, logic [W-1:0] sx,
                                        logic [W-1:0] sy, logic [W-1:0] q);
    logic [W-1:0] v;
    case (s)
      S_P:     v = p;
      S_ACFG:  v = ac;
      S_FX:    v = fx;
      S_FY:    v = fy;
      S_SX:    v = sx;
      S_SY:    v = sy;
      S_Q:     v = q;
      S_ONE:   v = W'(1);
      default: v = ram;
    endcase
    return v;
  endfunction

  always_comb begin
    va = pick(a_q, rdata_a, field_prime_i, curve_a_i, fx_q, fy_q, sx_q, sy_q, q_q);
    vb = pick(b_q, rdata_b, field_prime_i, curve_a_i, fx_q, fy_q, sx_q, sy_q, q_q);
    sum = {1'b0, va} + {1'b0, vb};
    case (op_q)
      OP_ADD:  simple = (sum >= p_ext) ? W'(sum - p_ext) : sum[W-1:0];
      OP_SUB:  simple = (va >= vb) ? (va - vb) : W'(({1'b0, va} + p_ext) - {1'b0, vb});
      OP_RED:  simple = (va >= vb) ? (va - vb) : va;
      default: simple = va;
    endcase
  end

  // one bit of the shift-add multiply or restoring divide
  always_comb begin
    t0 = '0;
    t1 = '0;
    t2 = '0;
    if (op_q == OP_DIV) begin
      t0 = {acc_q, sh_q[W-1]};
      t1 = (t0 >= {1'b0, opb_q}) ? (t0 - {1'b0, opb_q}) : t0;
      t2 = t1;
    end else begin
      t0 = {acc_q, 1'b0};
      t1 = (t0 >= p_ext) ? (t0 - p_ext) : t0;
      t1 = sh_q[W-1] ? (t1 + {1'b0, opb_q}) : t1;
      t2 = (t1 >= p_ext) ? (t1 - p_ext) : t1;
    end
  end

  assign wb_data = (op_q == OP_MUL || op_q == OP_DIV) ? acc_q : res_q;
  assign ram_we  = (st_q == D_WB) && (op_q == OP_MOV || op_q == OP_ADD || op_q == OP_SUB ||
                   op_q == OP_RED || op_q == OP_MUL || op_q == OP_DIV);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      D_IDLE:  if (cmd_i.start) st_d = D_FETCH;
      D_FETCH: st_d = (op_q == OP_MUL || op_q == OP_DIV) ? D_EXEC : D_WB;
      D_EXEC:  if (step_q == '0) st_d = D_WB;
      D_WB:    st_d = D_IDLE;
      default: st_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= D_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= operation_i;
      fx_q   <= first_x_i;
      fy_q   <= first_y_i;
      sx_q   <= second_x_i;
      sy_q   <= second_y_i;
      cnt_q  <= scalar_i;
    end else if (cmd_i.cnt_dec) begin
      cnt_q <= cnt_q - W'(1);
    end
    if (st_q == D_IDLE && cmd_i.start) begin
      op_q <= cmd_i.op;
      a_q  <= cmd_i.a;
      b_q  <= cmd_i.b;
      d_q  <= cmd_i.d;
    end
    if (st_q == D_FETCH) begin
      eq_q   <= (va == vb);
      az_q   <= (va == '0);
      res_q  <= simple;
      sh_q   <= va;
      opb_q  <= vb;
      acc_q  <= '0;
      step_q <= STEP_W'(W - 1);
    end
    if (st_q == D_EXEC) begin
      acc_q  <= t2[W-1:0];
      sh_q   <= {sh_q[W-2:0], (op_q == OP_DIV) && (t0 >= {1'b0, opb_q})};
      step_q <= step_q - STEP_W'(1);
    end
    if (st_q == D_WB) begin
      if (op_q == OP_DIV) q_q <= sh_q;
      if (op_q == OP_OUTX) resx_q <= res_q;
      if (op_q == OP_OUTY) resy_q <= res_q;
    end
    if (cmd_i.load_out) begin
      outx_q <= resx_q;
      outy_q <= resy_q;
    end
  end

  assign result_x_o        = outx_q;
  assign result_y_o        = outy_q;
  assign sts_o.done        = (st_q == D_WB);
  assign sts_o.eq          = eq_q;
  assign sts_o.az          = az_q;
  assign sts_o.mode_scalar = mode_q;
  assign sts_o.p_small     = (field_prime_i < W'(3));
  assign sts_o.cnt_zero    = (cnt_q == '0);
  assign sts_o.cnt_le1     = (cnt_q <= W'(1));

endmodule

FILE: rtl/ecpa_ctrl.sv
module ecpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_inf_o,
  output ecpa_pkg::dp_cmd_t cmd_o,
  input  ecpa_pkg::dp_sts_t sts_i
);
  import ecpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e st_q, st_d;
  pc_t    pc_q, pc_d;
  logic   rinf_q, rinf_d;
  logic   ov_q, ov_d, oinf_q, oinf_d;
  uop_t   u;
  logic   take, step;

  assign u = uop_at(pc_q);

  always_comb begin
    case (u.cond)
      C_ALWAYS: take = 1'b1;
      C_NE:     take = !sts_i.eq;
      C_AZ:     take = sts_i.az;
      C_SCALAR: take = sts_i.mode_scalar;
      C_PSMALL: take = sts_i.p_small;
      C_KZERO:  take = sts_i.cnt_zero;
      C_CNTLE1: take = sts_i.cnt_le1;
      C_RINF:   take = rinf_q;
      default:  take = 1'b0;
    endcase
  end

  always_comb begin
    st_d    = st_q;
    pc_d    = pc_q;
    rinf_d  = rinf_q;
    ov_d    = ov_q;
    oinf_d  = oinf_q;
    step    = 1'b0;
    cmd_o          = '0;
    cmd_o.op       = u.op;
    cmd_o.a        = u.a;
    cmd_o.b        = u.b;
    cmd_o.d        = u.d;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          rinf_d = 1'b1;
          pc_d   = '0;
          st_d   = S_RUN;
        end
      end
      S_RUN: begin
        if (u.op == OP_NOP) begin
          step = 1'b1;
        end else begin
          cmd_o.start = 1'b1;
          st_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts_i.done) begin
          step = 1'b1;
          st_d = S_RUN;
        end
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          ov_d   = 1'b1;
          oinf_d = rinf_q;
          st_d   = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
    if (step) begin
      pc_d = take ? u.tgt : pc_q + PC_W'(1);
      case (u.act)
        A_CLR_RINF: rinf_d = 1'b0;
        A_SET_RINF: rinf_d = 1'b1;
        A_CNT_DEC:  cmd_o.cnt_dec = 1'b1;
        A_FINISH:   st_d = S_DONE;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      pc_q   <= '0;
      rinf_q <= 1'b1;
      ov_q   <= 1'b0;
      oinf_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      pc_q   <= pc_d;
      rinf_q <= rinf_d;
      ov_q   <= ov_d;
      oinf_q <= oinf_d;
    end
  end

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_inf_o   = oinf_q;

endmodule

FILE: rtl/ec_point_add_and_scalar_mult_core.sv
// Affine point add and scalar multiply over GF(p), p and a set over APB. One item gives
// one result. A microcoded sequencer drives one modular ALU: a no-op microstep only
// advances the sequencer, add/sub/move/compare pass through issue, fetch and write back,
// and a bit-serial multiply or divide adds 16 bit steps between fetch and write back. A
// point addition includes operand reduction and an inverse by Euclid steps (at most
// about 23 steps for a 16-bit p). A scalar item runs up to k-1 scalar steps around the
// point addition. The result register lets the next item be taken while a result waits.
module ec_point_add_and_scalar_mult_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // first_x, first_y, second_x, second_y, scalar
  input  logic [79:0] s_axis_tdata,
  // operation
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_x, result_y
  output logic [31:0] m_axis_tdata,
  // at_infinity
  output logic [0:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ecpa_pkg::*;

  logic [15:0] prime_q, curve_a_q, rx, ry;
  logic        inf;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q   <= 16'd65521;
      curve_a_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) curve_a_q <= pwdata[15:0];
      else          prime_q   <= pwdata[15:0];
    end
  end

  assign prdata = paddr[2] ? {16'b0, curve_a_q} : {16'b0, prime_q};

  ecpa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_inf_o(inf), .cmd_o(cmd), .sts_i(sts)
  );

  ecpa_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .field_prime_i(prime_q), .curve_a_i(curve_a_q),
    .operation_i(s_axis_tuser[0]),
    .first_x_i(s_axis_tdata[15:0]), .first_y_i(s_axis_tdata[31:16]),
    .second_x_i(s_axis_tdata[47:32]), .second_y_i(s_axis_tdata[63:48]),
    .scalar_i(s_axis_tdata[79:64]),
    .result_x_o(rx), .result_y_o(ry)
  );

  assign m_axis_tdata = inf ? 32'b0 : {ry, rx};
  assign m_axis_tuser = inf;

endmodule

FILE: rtl/ecpa_checker.sv
`include "ec_point_add_and_scalar_mult_core_assert.svh"

module ecpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        pready
);

  `ECPA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "item dropped")
  `ECPA_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "data moved")
  `ECPA_ASSERT(a_inf_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'b0, "inf not zero")
  `ECPA_ASSERT(a_busy, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "took two items")
  `ECPA_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind ec_point_add_and_scalar_mult_core ecpa_checker u_ecpa_checker (.*);
